// ----- hw/rtl/rbg_pkg.sv -----
// Shared types and constants for the restart backoff gate.
package rbg_pkg;

    localparam int TIME_W      = 32;
    localparam int FIRST_GAP_W = 16;
    localparam int MAXPW_W     = 4;
    localparam int COUNT_W     = 4;
    localparam int CMD_W       = 2;
    localparam int CAUSE_W     = 2;
    localparam int CFG_IDX_W   = 4;
    localparam int NUM_CAUSES  = 3;
    localparam int NUM_BACKOFF = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY  = 2'd0,
        CMD_RECORD = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_PLAN     = 2'd0,
        CAUSE_RECOVERY = 2'd1,
        CAUSE_CRASH    = 2'd2,
        CAUSE_USER     = 2'd3
    } t_cause;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW    = 4'd0,
        CFG_FIRST_GAP = 4'd1,
        CFG_MAX_GAP   = 4'd2,
        CFG_MAX_PER   = 4'd3,
        CFG_BACKOFF0  = 4'd4
    } t_cfg_index;

    localparam logic [TIME_W-1:0]      WINDOW_RESET    = 32'd600;
    localparam logic [FIRST_GAP_W-1:0] FIRST_GAP_RESET = 16'd1;
    localparam logic [TIME_W-1:0]      MAX_GAP_RESET   = 32'd60;
    localparam logic [MAXPW_W-1:0]     MAX_PER_RESET   = 4'd3;
    localparam logic [TIME_W-1:0]      BACKOFF_RESET [NUM_BACKOFF] =
        '{32'd60, 32'd120, 32'd300, 32'd600};

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [CAUSE_W-1:0] cause;
        logic [TIME_W-1:0]  now_seconds;
    } t_in_item;

    typedef struct packed {
        logic [TIME_W-1:0]  earliest_time;
        logic               cap_reached;
        logic [COUNT_W-1:0] recent_count;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0]      window_seconds;
        logic [FIRST_GAP_W-1:0] first_gap_seconds;
        logic [TIME_W-1:0]      max_gap_seconds;
        logic [MAXPW_W-1:0]     max_per_window;
    } t_cfg;

    typedef enum logic [1:0] {
        ALU_STALE,
        ALU_SATADD,
        ALU_MAX
    } t_alu_op;

    typedef struct packed {
        t_alu_op           op;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
        logic [TIME_W-1:0] c;
    } t_alu_req;

    typedef struct packed {
        logic [TIME_W-1:0] value;
        logic              flag;
    } t_alu_res;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REC_WRITE,
        ST_PRUNE_RD,
        ST_PRUNE_CHK,
        ST_Q_WALK,
        ST_Q_GAP,
        ST_Q_ADD_GAP,
        ST_Q_MAX_NOW,
        ST_Q_ADD_BO,
        ST_Q_MAX_BO,
        ST_DONE
    } t_state;

endpackage

// ----- hw/rtl/restart_backoff_gate_core.sv -----
// Top level of the restart backoff gate: configuration registers, result register, sequencer.
//
//   Channel   Direction  Handshake                  Payload
//   in        sink       i_in_valid / o_in_ready    i_in_item  (cmd, cause, now_seconds)
//   out       source     o_out_valid / i_out_ready  o_out_item (earliest_time, cap_reached,
//                                                               recent_count)
//   cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A query walks the stored entries of its cause, adds the gap to the last entry, takes the
// maximum with now and, with the cap reached, adds a backoff step and takes a second maximum;
// with no entry in the window it ends after the gap step. A record writes, then prunes; each
// prune step reads then tests. No input is taken until
// the result is in the output register; a stalled output holds the next result in the core.
// Reset clears all histories and loads the default configuration; no memory sweep is needed.
module restart_backoff_gate_core #(
    parameter int HISTORY_DEPTH = 8,
    parameter int SHIFT_CAP     = 16,
    parameter int BACKOFF_STEPS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rbg_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rbg_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rbg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rbg_pkg::TIME_W-1:0]    i_cfg_data
);

    rbg_pkg::t_cfg               r_cfg;
    logic [rbg_pkg::TIME_W-1:0]  r_backoff [BACKOFF_STEPS];
    logic                        r_out_valid;
    rbg_pkg::t_out_item          r_out_item;

    logic                        cfg_wr;
    logic                        res_valid;
    logic                        res_ready;
    rbg_pkg::t_out_item          res;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_seconds    <= rbg_pkg::WINDOW_RESET;
            r_cfg.first_gap_seconds <= rbg_pkg::FIRST_GAP_RESET;
            r_cfg.max_gap_seconds   <= rbg_pkg::MAX_GAP_RESET;
            r_cfg.max_per_window    <= rbg_pkg::MAX_PER_RESET;
            for (int k = 0; k < BACKOFF_STEPS; k++) begin
                r_backoff[k] <= rbg_pkg::BACKOFF_RESET[k];
            end
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                rbg_pkg::CFG_WINDOW:    r_cfg.window_seconds <= i_cfg_data;
                rbg_pkg::CFG_FIRST_GAP: begin
                    r_cfg.first_gap_seconds <= i_cfg_data[rbg_pkg::FIRST_GAP_W-1:0];
                end
                rbg_pkg::CFG_MAX_GAP:   r_cfg.max_gap_seconds <= i_cfg_data;
                rbg_pkg::CFG_MAX_PER: begin
                    r_cfg.max_per_window <= i_cfg_data[rbg_pkg::MAXPW_W-1:0];
                end
                default: begin
                end
            endcase
            // Steps beyond the configured table size are accepted and dropped.
            for (int k = 0; k < BACKOFF_STEPS; k++) begin
                if (i_cfg_index == rbg_pkg::CFG_IDX_W'(rbg_pkg::CFG_BACKOFF0 + k)) begin
                    r_backoff[k] <= i_cfg_data;
                end
            end
        end
    end

    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    rbg_seq #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .SHIFT_CAP    (SHIFT_CAP),
        .BACKOFF_STEPS(BACKOFF_STEPS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_item      (i_in_item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .i_cfg       (r_cfg),
        .i_backoff   (r_backoff)
    );

endmodule

// ----- hw/rtl/rbg_hist_mem.sv -----
// History time memory: one ring of entries per cause, one write and one registered read port.
module rbg_hist_mem #(
    parameter int DEPTH = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [rbg_pkg::CAUSE_W-1:0]          i_wr_cause,
    input  logic [$clog2(DEPTH)-1:0]             i_wr_ptr,
    input  logic [rbg_pkg::TIME_W-1:0]           i_wr_data,
    input  logic                                 i_rd_en,
    input  logic [rbg_pkg::CAUSE_W-1:0]          i_rd_cause,
    input  logic [$clog2(DEPTH)-1:0]             i_rd_ptr,
    output logic [rbg_pkg::TIME_W-1:0]           o_rd_data
);

    localparam int ENTRIES = rbg_pkg::NUM_CAUSES * DEPTH;
    localparam int AW      = $clog2(ENTRIES);

    logic [rbg_pkg::TIME_W-1:0] r_mem [ENTRIES];
    logic [rbg_pkg::TIME_W-1:0] r_rd_data;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;

    assign wr_addr = AW'(i_wr_cause) * AW'(DEPTH) + AW'(i_wr_ptr);
    assign rd_addr = AW'(i_rd_cause) * AW'(DEPTH) + AW'(i_rd_ptr);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/rbg_alu.sv -----
// Shared time unit: staleness test, saturating add and maximum.
module rbg_alu (
    input  rbg_pkg::t_alu_req i_req,
    output rbg_pkg::t_alu_res o_res
);

    logic [rbg_pkg::TIME_W:0] sum;
    logic [rbg_pkg::TIME_W:0] diff;
    logic                     borrow;

    assign sum    = {1'b0, i_req.a} + {1'b0, i_req.b};
    assign diff   = {1'b0, i_req.a} - {1'b0, i_req.b};
    assign borrow = diff[rbg_pkg::TIME_W];

    always_comb begin
        o_res = '0;
        unique case (i_req.op)
            rbg_pkg::ALU_STALE: begin
                // Stale means a >= b and the age a - b exceeds the window in c.
                o_res.value = diff[rbg_pkg::TIME_W-1:0];
                o_res.flag  = !borrow && (diff[rbg_pkg::TIME_W-1:0] > i_req.c);
            end
            rbg_pkg::ALU_SATADD: begin
                o_res.value = sum[rbg_pkg::TIME_W] ? '1 : sum[rbg_pkg::TIME_W-1:0];
                o_res.flag  = sum[rbg_pkg::TIME_W];
            end
            rbg_pkg::ALU_MAX: begin
                o_res.value = borrow ? i_req.b : i_req.a;
                o_res.flag  = borrow;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/rbg_seq.sv -----
// Sequencer: walks the history ring of one cause through the shared time unit.
module rbg_seq #(
    parameter int HISTORY_DEPTH = 8,
    parameter int SHIFT_CAP     = 16,
    parameter int BACKOFF_STEPS = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  rbg_pkg::t_in_item          i_item,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output rbg_pkg::t_out_item         o_res,
    input  rbg_pkg::t_cfg              i_cfg,
    input  logic [rbg_pkg::TIME_W-1:0] i_backoff [BACKOFF_STEPS]
);

    localparam int PW    = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int XW    = CNT_W + 1;
    localparam int CMPW  = (CNT_W > rbg_pkg::MAXPW_W) ? CNT_W : rbg_pkg::MAXPW_W;
    localparam int GW    = rbg_pkg::FIRST_GAP_W + SHIFT_CAP;
    localparam int CW    = (GW > rbg_pkg::TIME_W) ? GW : rbg_pkg::TIME_W;
    localparam int SH_W  = $clog2(SHIFT_CAP + 1);
    localparam int BS_W  = (BACKOFF_STEPS > 1) ? $clog2(BACKOFF_STEPS) : 1;

    rbg_pkg::t_state                 r_state;
    rbg_pkg::t_state                 n_state;
    logic [rbg_pkg::CAUSE_W-1:0]     r_cause;
    logic [rbg_pkg::TIME_W-1:0]      r_now;
    logic [PW-1:0]                   r_wp  [rbg_pkg::NUM_CAUSES];
    logic [CNT_W-1:0]                r_cnt [rbg_pkg::NUM_CAUSES];
    logic [PW-1:0]                   r_ptr;
    logic [CNT_W-1:0]                r_left;
    logic                            r_pend;
    logic                            r_first;
    logic [CNT_W-1:0]                r_recent;
    logic [rbg_pkg::TIME_W-1:0]      r_last;
    logic [rbg_pkg::TIME_W-1:0]      r_gap;
    logic [rbg_pkg::TIME_W-1:0]      r_at;
    logic [rbg_pkg::TIME_W-1:0]      r_bo;
    logic                            r_cap;
    rbg_pkg::t_out_item              r_res;

    logic                            accept;
    logic [rbg_pkg::CAUSE_W-1:0]     sel_cause;
    logic [PW-1:0]                   cur_wp;
    logic [CNT_W-1:0]                cur_cnt;
    logic [PW-1:0]                   oldest;
    logic [CNT_W-1:0]                cnt_m1;
    logic [SH_W-1:0]                 shamt;
    logic [GW-1:0]                   gap_shift;
    logic [CW-1:0]                   gap_ext;
    logic [rbg_pkg::TIME_W-1:0]      gap_capped;
    logic                            cap_flag;
    logic [CMPW-1:0]                 step_diff;
    logic [BS_W-1:0]                 step_idx;

    logic                            mem_wr_en;
    logic                            mem_rd_en;
    logic [PW-1:0]                   mem_rd_ptr;
    logic [rbg_pkg::TIME_W-1:0]      rd_data;
    rbg_pkg::t_alu_req               alu_req;
    rbg_pkg::t_alu_res               alu_res;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(HISTORY_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        ptr_dec = (p == '0) ? PW'(HISTORY_DEPTH - 1) : p - PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_back(input logic [PW-1:0] wp,
                                               input logic [CNT_W-1:0] n);
        logic [XW-1:0] w;
        logic [XW-1:0] c;
        logic [XW-1:0] r;
        w = XW'(wp);
        c = XW'(n);
        if (w >= c) begin
            r = w - c;
        end else begin
            r = w + XW'(HISTORY_DEPTH) - c;
        end
        ptr_back = r[PW-1:0];
    endfunction

    assign accept    = i_valid && (r_state == rbg_pkg::ST_IDLE);
    assign sel_cause = (r_state == rbg_pkg::ST_IDLE) ? i_item.cause : r_cause;
    assign cur_wp    = (sel_cause == rbg_pkg::CAUSE_USER) ? '0 : r_wp[sel_cause];
    assign cur_cnt   = (sel_cause == rbg_pkg::CAUSE_USER) ? '0 : r_cnt[sel_cause];
    assign oldest    = ptr_back(cur_wp, cur_cnt);

    // Exponential gap: first gap doubled per recent entry beyond one, then capped.
    always_comb begin
        cnt_m1 = r_recent - CNT_W'(1);
        if (32'(cnt_m1) > 32'(SHIFT_CAP)) begin
            shamt = SH_W'(SHIFT_CAP);
        end else begin
            shamt = SH_W'(cnt_m1);
        end
        gap_shift = GW'(i_cfg.first_gap_seconds) << shamt;
        gap_ext   = CW'(gap_shift);
        if (gap_ext > CW'(i_cfg.max_gap_seconds)) begin
            gap_capped = i_cfg.max_gap_seconds;
        end else begin
            gap_capped = gap_ext[rbg_pkg::TIME_W-1:0];
        end
    end

    always_comb begin
        cap_flag  = (r_cause != rbg_pkg::CAUSE_CRASH)
                    && (CMPW'(r_recent) >= CMPW'(i_cfg.max_per_window));
        step_diff = CMPW'(r_recent) - CMPW'(i_cfg.max_per_window);
        if (step_diff > CMPW'(BACKOFF_STEPS - 1)) begin
            step_idx = BS_W'(BACKOFF_STEPS - 1);
        end else begin
            step_idx = BS_W'(step_diff);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rbg_pkg::ST_IDLE: begin
                if (accept) begin
                    priority if (i_item.cause == rbg_pkg::CAUSE_USER) begin
                        n_state = rbg_pkg::ST_DONE;
                    end else if (i_item.cmd == rbg_pkg::CMD_QUERY) begin
                        n_state = rbg_pkg::ST_Q_WALK;
                    end else if (i_item.cmd == rbg_pkg::CMD_RECORD) begin
                        n_state = rbg_pkg::ST_REC_WRITE;
                    end else begin
                        n_state = rbg_pkg::ST_DONE;
                    end
                end
            end
            rbg_pkg::ST_REC_WRITE: n_state = rbg_pkg::ST_PRUNE_RD;
            rbg_pkg::ST_PRUNE_RD:  n_state = rbg_pkg::ST_PRUNE_CHK;
            rbg_pkg::ST_PRUNE_CHK: begin
                n_state = alu_res.flag ? rbg_pkg::ST_PRUNE_RD : rbg_pkg::ST_DONE;
            end
            rbg_pkg::ST_Q_WALK: begin
                if (r_left == '0 && !r_pend) begin
                    n_state = rbg_pkg::ST_Q_GAP;
                end
            end
            rbg_pkg::ST_Q_GAP: begin
                n_state = (r_recent == '0) ? rbg_pkg::ST_DONE : rbg_pkg::ST_Q_ADD_GAP;
            end
            rbg_pkg::ST_Q_ADD_GAP: n_state = rbg_pkg::ST_Q_MAX_NOW;
            rbg_pkg::ST_Q_MAX_NOW: begin
                n_state = r_cap ? rbg_pkg::ST_Q_ADD_BO : rbg_pkg::ST_DONE;
            end
            rbg_pkg::ST_Q_ADD_BO:  n_state = rbg_pkg::ST_Q_MAX_BO;
            rbg_pkg::ST_Q_MAX_BO:  n_state = rbg_pkg::ST_DONE;
            rbg_pkg::ST_DONE: begin
                if (i_res_ready) begin
                    n_state = rbg_pkg::ST_IDLE;
                end
            end
            default: n_state = rbg_pkg::ST_IDLE;
        endcase
    end

    // Control outputs: memory ports and the shared unit's operands.
    always_comb begin
        o_ready     = (r_state == rbg_pkg::ST_IDLE);
        o_res_valid = (r_state == rbg_pkg::ST_DONE);
        mem_wr_en   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_ptr  = r_ptr;
        alu_req.op  = rbg_pkg::ALU_STALE;
        alu_req.a   = r_now;
        alu_req.b   = rd_data;
        alu_req.c   = i_cfg.window_seconds;
        unique case (r_state)
            rbg_pkg::ST_REC_WRITE: begin
                mem_wr_en = 1'b1;
            end
            rbg_pkg::ST_PRUNE_RD: begin
                mem_rd_en  = 1'b1;
                mem_rd_ptr = oldest;
            end
            rbg_pkg::ST_Q_WALK: begin
                mem_rd_en = (r_left != '0);
            end
            rbg_pkg::ST_Q_ADD_GAP: begin
                alu_req.op = rbg_pkg::ALU_SATADD;
                alu_req.a  = r_last;
                alu_req.b  = r_gap;
            end
            rbg_pkg::ST_Q_MAX_NOW: begin
                alu_req.op = rbg_pkg::ALU_MAX;
                alu_req.a  = r_at;
                alu_req.b  = r_now;
            end
            rbg_pkg::ST_Q_ADD_BO: begin
                alu_req.op = rbg_pkg::ALU_SATADD;
                alu_req.a  = r_last;
                alu_req.b  = i_backoff[step_idx];
            end
            rbg_pkg::ST_Q_MAX_BO: begin
                alu_req.op = rbg_pkg::ALU_MAX;
                alu_req.a  = r_at;
                alu_req.b  = r_bo;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbg_pkg::ST_IDLE;
            for (int c = 0; c < rbg_pkg::NUM_CAUSES; c++) begin
                r_wp[c]  <= '0;
                r_cnt[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (accept && i_item.cmd == rbg_pkg::CMD_CLEAR) begin
                for (int c = 0; c < rbg_pkg::NUM_CAUSES; c++) begin
                    r_wp[c]  <= '0;
                    r_cnt[c] <= '0;
                end
            end
            if (r_state == rbg_pkg::ST_REC_WRITE) begin
                r_wp[r_cause] <= ptr_inc(cur_wp);
                if (cur_cnt != CNT_W'(HISTORY_DEPTH)) begin
                    r_cnt[r_cause] <= cur_cnt + CNT_W'(1);
                end
            end
            // The entry just written is never stale, so this stops before the ring empties.
            if (r_state == rbg_pkg::ST_PRUNE_CHK && alu_res.flag) begin
                r_cnt[r_cause] <= cur_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            rbg_pkg::ST_IDLE: begin
                if (accept) begin
                    r_cause  <= i_item.cause;
                    r_now    <= i_item.now_seconds;
                    r_ptr    <= ptr_dec(cur_wp);
                    r_left   <= cur_cnt;
                    r_pend   <= 1'b0;
                    r_first  <= 1'b1;
                    r_recent <= '0;
                    r_res    <= '0;
                    if (i_item.cmd == rbg_pkg::CMD_QUERY) begin
                        r_res.earliest_time <= i_item.now_seconds;
                    end
                end
            end
            rbg_pkg::ST_Q_WALK: begin
                // Reads are issued newest first; each check happens in the cycle after its read.
                if (r_left != '0) begin
                    r_ptr  <= ptr_dec(r_ptr);
                    r_left <= r_left - CNT_W'(1);
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
                if (r_pend) begin
                    if (!alu_res.flag) begin
                        r_recent <= r_recent + CNT_W'(1);
                    end
                    if (r_first) begin
                        r_last  <= rd_data;
                        r_first <= 1'b0;
                    end
                end
            end
            rbg_pkg::ST_Q_GAP: begin
                r_gap <= gap_capped;
                r_cap <= cap_flag;
                r_res.cap_reached  <= cap_flag;
                r_res.recent_count <= rbg_pkg::COUNT_W'(r_recent);
            end
            rbg_pkg::ST_Q_ADD_GAP: begin
                r_at <= alu_res.value;
            end
            rbg_pkg::ST_Q_MAX_NOW: begin
                r_at                <= alu_res.value;
                r_res.earliest_time <= alu_res.value;
            end
            rbg_pkg::ST_Q_ADD_BO: begin
                r_bo <= alu_res.value;
            end
            rbg_pkg::ST_Q_MAX_BO: begin
                r_res.earliest_time <= alu_res.value;
            end
            default: begin
            end
        endcase
    end

    assign o_res = r_res;

    rbg_hist_mem #(
        .DEPTH(HISTORY_DEPTH)
    ) u_mem (
        .i_clk      (i_clk),
        .i_wr_en    (mem_wr_en),
        .i_wr_cause (r_cause),
        .i_wr_ptr   (cur_wp),
        .i_wr_data  (r_now),
        .i_rd_en    (mem_rd_en),
        .i_rd_cause (r_cause),
        .i_rd_ptr   (mem_rd_ptr),
        .o_rd_data  (rd_data)
    );

    rbg_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res)
    );

endmodule
